>>> hw/rtl/decimal_scaled_alu_defines.svh
// Assertion macros shared by the decimal scaled ALU RTL.
`ifndef DECIMAL_SCALED_ALU_DEFINES_SVH
`define DECIMAL_SCALED_ALU_DEFINES_SVH

// Same-cycle implication, checked on every rising clk edge outside reset.
`define DSA_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising clk edge outside reset.
`define DSA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/dsa_pkg.sv
// Shared types and constants for the decimal scaled ALU.
package dsa_pkg;

  // Mantissa and exponent width
  localparam int MANT_W = 64;

  // Loop counter holds 0 .. MANT_W
  localparam int CNT_W = $clog2(MANT_W + 1);

  // Operation codes carried by the action field
  typedef enum logic [2:0] {
    ACT_ADD = 3'd0,
    ACT_SUB = 3'd1,
    ACT_MUL = 3'd2,
    ACT_DIV = 3'd3,
    ACT_GE  = 3'd4
  } action_t;

  // Flips the sign bit so signed order becomes unsigned order
  localparam logic [MANT_W-1:0] SIGN_MASK = {1'b1, {(MANT_W-1){1'b0}}};

endpackage

>>> hw/rtl/decimal_scaled_alu.sv
// Decimal scaled ALU: add, subtract, multiply, divide and compare on mantissa/exponent pairs.
//
// One word in, one word out, computed on a single shared 65-bit adder under a small
// sequencer; the block takes no new word until the current one has finished. Add,
// subtract and compare first scale the mantissa with the larger exponent by ten once
// per decade of exponent difference (no scaling when the difference reaches 64, since
// the aligned mantissa is then zero); multiply is shift-and-add, one multiplier bit per
// cycle; divide runs two sign-removal passes, then restoring division one quotient bit
// per cycle; divide by zero and unused codes go straight to the last step. The adder
// loop sets how long each operation runs. A finished result waits in the output register
// while the next word is accepted; the sequencer stalls in its last step only if that
// register is still full when the next result is ready.
`include "decimal_scaled_alu_defines.svh"

module decimal_scaled_alu
  import dsa_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [2:0]               action,
  input  logic signed [MANT_W-1:0] left_mantissa,
  input  logic signed [MANT_W-1:0] left_exponent,
  input  logic signed [MANT_W-1:0] right_mantissa,
  input  logic signed [MANT_W-1:0] right_exponent,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic signed [MANT_W-1:0] result_mantissa,
  output logic signed [MANT_W-1:0] result_exponent,
  output logic                     greater_or_equal,
  output logic                     divide_by_zero
);

  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(MANT_W);
  localparam int SHIFT_W = $clog2(MANT_W);

  // Sequencer states
  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_ALIGN = 7'b0000010,
    S_MUL   = 7'b0000100,
    S_ABSL  = 7'b0001000,
    S_ABSR  = 7'b0010000,
    S_DIV   = 7'b0100000,
    S_FIX   = 7'b1000000
  } state_t;

  state_t             state;
  action_t            act;
  logic [MANT_W-1:0]  ma;          // left operand / dividend-quotient / multiplicand
  logic [MANT_W-1:0]  mb;          // right operand / divisor / multiplier
  logic [MANT_W-1:0]  acc;         // product accumulator or division remainder
  logic [MANT_W-1:0]  expo;
  logic [CNT_W-1:0]   cnt;
  logic               scale_left;
  logic               lneg;
  logic               rneg;
  logic               dz;

  // Exponent compare and alignment distance, evaluated on the incoming word
  logic               left_bigger;
  logic [MANT_W-1:0]  diff_lr;
  logic [MANT_W-1:0]  diff_rl;
  logic [MANT_W-1:0]  diff;
  logic               far;
  logic [MANT_W-1:0]  emin;
  logic               is_align;
  logic               div_zero;
  logic [CNT_W-1:0]   align_cnt;

  assign left_bigger = right_exponent < left_exponent;
  assign diff_lr     = left_exponent - right_exponent;
  assign diff_rl     = right_exponent - left_exponent;
  assign diff        = left_bigger ? diff_lr : diff_rl;
  assign far         = |diff[MANT_W-1:SHIFT_W];
  assign emin        = left_bigger ? right_exponent : left_exponent;
  assign is_align    = (action == ACT_ADD) || (action == ACT_SUB) || (action == ACT_GE);
  assign div_zero    = (action == ACT_DIV) && (right_mantissa == '0);
  assign align_cnt   = far ? '0 : {1'b0, diff[SHIFT_W-1:0]};

  // Shared adder
  logic [MANT_W-1:0]  add_a;
  logic [MANT_W-1:0]  add_b;
  logic               add_cin;
  logic [MANT_W:0]    sum;
  logic               carry;
  logic [MANT_W-1:0]  align_src;
  logic [MANT_W-1:0]  rem_sh;

  assign align_src = scale_left ? ma : mb;
  assign rem_sh    = {acc[MANT_W-2:0], ma[MANT_W-1]};

  always_comb begin
    add_a   = '0;
    add_b   = '0;
    add_cin = 1'b0;
    unique case (state)
      S_ALIGN: begin
        // x*10 = x*8 + x*2
        add_a = align_src << 3;
        add_b = align_src << 1;
      end
      S_MUL: begin
        add_a = acc;
        add_b = ma;
      end
      S_ABSL: begin
        add_a   = ~ma;
        add_cin = 1'b1;
      end
      S_ABSR: begin
        add_a   = ~mb;
        add_cin = 1'b1;
      end
      S_DIV: begin
        add_a   = rem_sh;
        add_b   = ~mb;
        add_cin = 1'b1;
      end
      S_FIX: begin
        case (act)
          ACT_ADD: begin
            add_a = ma;
            add_b = mb;
          end
          ACT_SUB: begin
            add_a   = ma;
            add_b   = ~mb;
            add_cin = 1'b1;
          end
          ACT_GE: begin
            add_a   = ma ^ SIGN_MASK;
            add_b   = ~(mb ^ SIGN_MASK);
            add_cin = 1'b1;
          end
          ACT_DIV: begin
            add_a   = ~ma;
            add_cin = 1'b1;
          end
          default: begin
            add_a = '0;
          end
        endcase
      end
      default: begin
        add_a = '0;
      end
    endcase
  end

  assign sum   = {1'b0, add_a} + {1'b0, add_b} + {{MANT_W{1'b0}}, add_cin};
  assign carry = sum[MANT_W];

  assign in_ready = (state == S_IDLE);

  // Final mantissa and compare flag, formed in the last step
  logic [MANT_W-1:0] fin_mant;
  logic              fin_ge;

  always_comb begin
    fin_mant = '0;
    fin_ge   = 1'b0;
    case (act)
      ACT_ADD, ACT_SUB: fin_mant = sum[MANT_W-1:0];
      ACT_GE:           fin_ge   = carry;
      ACT_MUL:          fin_mant = acc;
      ACT_DIV: begin
        if (!dz) begin
          fin_mant = (lneg ^ rneg) ? sum[MANT_W-1:0] : ma;
        end
      end
      default:          fin_mant = '0;
    endcase
  end

  // Sequencer and datapath registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      // the last step reloads the output register itself
      if (out_valid && out_ready && (state != S_FIX)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            act        <= action_t'(action);
            lneg       <= left_mantissa[MANT_W-1];
            rneg       <= right_mantissa[MANT_W-1];
            acc        <= '0;
            dz         <= div_zero;
            scale_left <= left_bigger;
            // 64 or more decades clear the aligned mantissa
            ma  <= (is_align && far && left_bigger) ? '0 : left_mantissa;
            mb  <= (is_align && far && !left_bigger) ? '0 : right_mantissa;
            cnt <= is_align ? align_cnt : CNT_FULL;
            case (action_t'(action))
              ACT_ADD, ACT_SUB, ACT_GE: begin
                expo  <= (action_t'(action) == ACT_GE) ? '0 : emin;
                state <= S_ALIGN;
              end
              ACT_MUL: begin
                expo  <= left_exponent + right_exponent;
                state <= S_MUL;
              end
              ACT_DIV: begin
                expo <= diff_lr;
                if (div_zero) begin
                  state <= S_FIX;
                end else begin
                  state <= S_ABSL;
                end
              end
              default: begin
                expo  <= '0;
                state <= S_FIX;
              end
            endcase
          end
        end
        S_ALIGN: begin
          if (cnt == '0) begin
            state <= S_FIX;
          end else begin
            if (scale_left) begin
              ma <= sum[MANT_W-1:0];
            end else begin
              mb <= sum[MANT_W-1:0];
            end
            cnt <= cnt - 1'b1;
          end
        end
        S_MUL: begin
          if (cnt == '0) begin
            state <= S_FIX;
          end else begin
            if (mb[0]) begin
              acc <= sum[MANT_W-1:0];
            end
            ma  <= ma << 1;
            mb  <= mb >> 1;
            cnt <= cnt - 1'b1;
          end
        end
        S_ABSL: begin
          if (lneg) begin
            ma <= sum[MANT_W-1:0];
          end
          state <= S_ABSR;
        end
        S_ABSR: begin
          if (rneg) begin
            mb <= sum[MANT_W-1:0];
          end
          state <= S_DIV;
        end
        S_DIV: begin
          // restoring step: trial subtract, keep on no borrow
          if (cnt == '0) begin
            state <= S_FIX;
          end else begin
            acc <= carry ? sum[MANT_W-1:0] : rem_sh;
            ma  <= {ma[MANT_W-2:0], carry};
            cnt <= cnt - 1'b1;
          end
        end
        S_FIX: begin
          if (!out_valid || out_ready) begin
            result_mantissa  <= fin_mant;
            result_exponent  <= expo;
            greater_or_equal <= fin_ge;
            divide_by_zero   <= dz;
            out_valid        <= 1'b1;
            state            <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Checks
  `DSA_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready,
                   "block still ready after accepting a word")
  `DSA_ASSERT_NOW(a_div_rem_bound, state == S_DIV, acc < mb,
                  "division remainder not below divisor")
  `DSA_ASSERT_NEXT(a_mul_done, (state == S_MUL) && (cnt == '0), state == S_FIX,
                   "multiply loop did not finish")
  `DSA_ASSERT_NOW(a_dz_zero, out_valid && divide_by_zero, result_mantissa == '0,
                  "divide by zero with nonzero mantissa")
  `DSA_ASSERT_NOW(a_ge_clean, out_valid && greater_or_equal,
                  (result_mantissa == '0) && (result_exponent == '0) && !divide_by_zero,
                  "compare result carries mantissa, exponent or flag")

endmodule
